// ===== rtl/categorical_inverse_cdf_sampler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Categorical sampler assertion macros
// Shared macros for the concurrent checks of the categorical sampler.
// ----------------------------------------------------------------------------
`ifndef CATEGORICAL_INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH
`define CATEGORICAL_INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CICS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CICS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/cics_pkg.sv =====
// ----------------------------------------------------------------------------
// Categorical sampler package
// Field widths, register indexes and codes shared by the sampler files.
// ----------------------------------------------------------------------------
package cics_pkg;

  localparam int MAX_BINS_DEF    = 64;
  localparam int BIN_FIELD_LIMIT = 64;

  localparam int BIN_W      = 6;
  localparam int WEIGHT_W   = 16;
  localparam int UNIF_W     = 32;
  localparam int CUM_W      = 22;
  localparam int COUNT_W    = 7;
  localparam int CHOSEN_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W     = UNIF_W + CUM_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE  = 1'd1;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

endpackage

// ===== rtl/cics_in_if.sv =====
// ----------------------------------------------------------------------------
// Sampler request channel
// Valid/ready channel carrying one load or draw request word.
// ----------------------------------------------------------------------------
interface cics_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [cics_pkg::BIN_W-1:0]        bin_number;
  logic [cics_pkg::WEIGHT_W-1:0]     weight;
  logic [cics_pkg::UNIF_W-1:0]       uniform;

  modport source (output valid, req_type, bin_number, weight, uniform, input ready);
  modport sink   (input valid, req_type, bin_number, weight, uniform, output ready);
endinterface

// ===== rtl/cics_out_if.sv =====
// ----------------------------------------------------------------------------
// Sampler result channel
// Valid/ready channel carrying one draw result word.
// ----------------------------------------------------------------------------
interface cics_out_if;
  logic                              valid;
  logic                              ready;
  logic [cics_pkg::CHOSEN_W-1:0]     chosen_bin;
  logic                              status;

  modport source (output valid, chosen_bin, status, input ready);
  modport sink   (input valid, chosen_bin, status, output ready);
endinterface

// ===== rtl/cics_cum_ram.sv =====
// ----------------------------------------------------------------------------
// Cumulative weight memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cics_cum_ram #(
  parameter int DEPTH = cics_pkg::MAX_BINS_DEF,
  parameter int AW    = $clog2(cics_pkg::MAX_BINS_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cics_pkg::CUM_W-1:0]  wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [cics_pkg::CUM_W-1:0]  rd_data
);

  logic [cics_pkg::CUM_W-1:0] mem [DEPTH];
  logic [cics_pkg::CUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/categorical_inverse_cdf_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Categorical inverse-CDF sampler
// Loads bin weights as a running cumulative sum and draws bins by linear search.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and drops ready until that word
// is finished. A load word (req_type 0) adds its weight to the cumulative weight
// of the bin below it, saturating at 2^22 - 1, and stores the sum for its own
// bin; it gives no result, and the next word can be accepted after ST_LD_RD and
// ST_LD_WR. A draw word (req_type 1) multiplies its uniform fraction by the total
// weight of the last bin in use and then walks the cumulative table from bin 0
// upward, one bin per cycle, until the scaled target no longer exceeds the bin's
// cumulative weight or the last bin in use is reached. A draw passes through
// ST_DR_RD, ST_DR_TOT, ST_SEARCH (skipped for a zero total) and ST_RESULT; each
// compare needs one read of the memory's single read port. If the previous
// result still waits in the output register, the draw holds in ST_RESULT until
// that word is collected. A finished result sits in an output register, so a new
// word is taken while it waits to be collected. A zero total returns status 1
// with chosen_bin 0. Weights are meant to be loaded in ascending bin order; the
// cumulative memory holds no defined value until a bin is loaded. The user must
// write configuration only while the block is idle; the block does not enforce it.
module categorical_inverse_cdf_sampler_unit #(
  parameter int MAX_BINS = cics_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cics_in_if.sink                             in_ch,
  cics_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cics_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cics_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW      = $clog2(MAX_BINS);
  localparam int CAP_INT = (MAX_BINS < cics_pkg::BIN_FIELD_LIMIT) ?
                           MAX_BINS : cics_pkg::BIN_FIELD_LIMIT;
  localparam logic [cics_pkg::COUNT_W-1:0] ACTIVE_CAP = cics_pkg::COUNT_W'(CAP_INT);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LD_RD  = 7'b0000010,
    ST_LD_WR  = 7'b0000100,
    ST_DR_RD  = 7'b0001000,
    ST_DR_TOT = 7'b0010000,
    ST_SEARCH = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [cics_pkg::COUNT_W-1:0]  bins_cfg_r, bins_cfg_nxt;
  logic                          base_r, base_nxt;

  // Request payload captured at acceptance.
  logic [cics_pkg::BIN_W-1:0]    bin_r, bin_nxt;
  logic [cics_pkg::WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [cics_pkg::UNIF_W-1:0]   uniform_r, uniform_nxt;
  logic [cics_pkg::COUNT_W-1:0]  nbins_r, nbins_nxt;

  // Search datapath.
  logic [cics_pkg::COUNT_W-1:0]  k_r, k_nxt;
  logic [cics_pkg::PROD_W-1:0]   target_r, target_nxt;
  logic [cics_pkg::CHOSEN_W-1:0] res_bin_r, res_bin_nxt;
  logic                          res_status_r, res_status_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [cics_pkg::CHOSEN_W-1:0] out_bin_r, out_bin_nxt;
  logic                          out_status_r, out_status_nxt;

  // Memory ports.
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [cics_pkg::CUM_W-1:0]    ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [cics_pkg::CUM_W-1:0]    ram_rdata;

  logic                          accept;
  logic                          slot_free;
  logic [cics_pkg::COUNT_W-1:0]  active_bins;
  logic                          load_in_range;
  logic [cics_pkg::CUM_W-1:0]    prev_cum;
  logic [cics_pkg::CUM_W:0]      load_sum;
  logic                          hit;
  logic [cics_pkg::COUNT_W-1:0]  k_prev;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Bins in use: zero counts as one, anything above the storage is clamped.
  always_comb begin
    if (bins_cfg_r == '0) begin
      active_bins = cics_pkg::COUNT_W'(1);
    end else if (bins_cfg_r > ACTIVE_CAP) begin
      active_bins = ACTIVE_CAP;
    end else begin
      active_bins = bins_cfg_r;
    end
  end

  // Load arithmetic: previous cumulative weight plus the new weight, saturated.
  assign load_in_range = (32'(bin_r) < MAX_BINS);
  assign prev_cum      = (bin_r == '0) ? '0 : ram_rdata;
  assign load_sum      = {1'b0, prev_cum} + (cics_pkg::CUM_W + 1)'(weight_r);

  assign ram_we    = (state_r == ST_LD_WR) && load_in_range;
  assign ram_waddr = AW'(bin_r);
  assign ram_wdata = load_sum[cics_pkg::CUM_W] ? '1 : load_sum[cics_pkg::CUM_W-1:0];

  // Search compare: the read data belongs to bin k_r - 1.
  assign k_prev = k_r - cics_pkg::COUNT_W'(1);
  assign hit    = (target_r <= {ram_rdata, cics_pkg::UNIF_W'(0)});

  // Read address for the memory; the data appears in the following cycle.
  always_comb begin
    unique case (state_r)
      ST_LD_RD:  ram_raddr = AW'(bin_r - cics_pkg::BIN_W'(1));
      ST_DR_RD:  ram_raddr = AW'(nbins_r - cics_pkg::COUNT_W'(1));
      ST_SEARCH: ram_raddr = AW'(k_r);
      default:   ram_raddr = '0;
    endcase
  end

  // Configuration writes.
  always_comb begin
    bins_cfg_nxt = bins_cfg_r;
    base_nxt     = base_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cics_pkg::CFG_BINS_IN_USE: bins_cfg_nxt = cfg_wdata;
        cics_pkg::CFG_INDEX_BASE:  base_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    bin_nxt        = bin_r;
    weight_nxt     = weight_r;
    uniform_nxt    = uniform_r;
    nbins_nxt      = nbins_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    res_bin_nxt    = res_bin_r;
    res_status_nxt = res_status_r;
    out_bin_nxt    = out_bin_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          bin_nxt     = in_ch.bin_number;
          weight_nxt  = in_ch.weight;
          uniform_nxt = in_ch.uniform;
          nbins_nxt   = active_bins;
          state_nxt   = (in_ch.req_type == cics_pkg::REQ_DRAW) ? ST_DR_RD : ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        state_nxt = ST_IDLE;
      end
      ST_DR_RD: begin
        state_nxt = ST_DR_TOT;
      end
      ST_DR_TOT: begin
        // Read data is the total; the read issued here fetches bin 0.
        if (ram_rdata == '0) begin
          res_bin_nxt    = '0;
          res_status_nxt = cics_pkg::STATUS_ZERO;
          state_nxt      = ST_RESULT;
        end else begin
          target_nxt = cics_pkg::PROD_W'(uniform_r) * cics_pkg::PROD_W'(ram_rdata);
          k_nxt      = cics_pkg::COUNT_W'(1);
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The last bin in use is taken when nothing earlier satisfies the compare.
        if (hit || (k_r == nbins_r)) begin
          res_bin_nxt    = cics_pkg::CHOSEN_W'(k_prev) + cics_pkg::CHOSEN_W'(base_r);
          res_status_nxt = cics_pkg::STATUS_OK;
          state_nxt      = ST_RESULT;
        end else begin
          k_nxt = k_r + cics_pkg::COUNT_W'(1);
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_bin_nxt    = res_bin_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bins_cfg_r  <= cics_pkg::COUNT_W'(1);
      base_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bins_cfg_r  <= bins_cfg_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bin_r        <= bin_nxt;
    weight_r     <= weight_nxt;
    uniform_r    <= uniform_nxt;
    nbins_r      <= nbins_nxt;
    k_r          <= k_nxt;
    target_r     <= target_nxt;
    res_bin_r    <= res_bin_nxt;
    res_status_r <= res_status_nxt;
    out_bin_r    <= out_bin_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.chosen_bin = out_bin_r;
  assign out_ch.status     = out_status_r;

  cics_cum_ram #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_cum_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule

// ===== rtl/cics_checker.sv =====
// ----------------------------------------------------------------------------
// Categorical sampler port checker
// Concurrent checks on the sampler's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "categorical_inverse_cdf_sampler_unit_defines.svh"

module cics_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_req_type,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cics_pkg::CHOSEN_W-1:0]       out_chosen_bin,
  input logic                                out_status
);

  // A waiting result holds its word until it is taken.
  `CICS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_chosen_bin) && $stable(out_status))

  // Every accepted word drops ready in the following cycle.
  `CICS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A load never raises a result in the following cycle.
  `CICS_ASSERT_NEXT(a_load_silent, clk, rst_n, in_valid && in_ready && (in_req_type == cics_pkg::REQ_LOAD) && !out_valid, !out_valid)

  // A zero-total result carries bin zero.
  `CICS_ASSERT_IMPL(a_zero_bin, clk, rst_n, out_valid && (out_status == cics_pkg::STATUS_ZERO), out_chosen_bin == '0)

endmodule

bind categorical_inverse_cdf_sampler_unit cics_checker u_cics_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_req_type    (in_ch.req_type),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_chosen_bin (out_ch.chosen_bin),
  .out_status     (out_ch.status)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Categorical sampler testbench
// Streams load and draw words through the sampler with random idling on both
// channels, predicts every draw from a local cumulative table and checks it.
// ----------------------------------------------------------------------------
module tb_top;

  // Cycles with no handshake and no register write before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // A load gives no result, so after the last result the block may still be busy
  // with a load.
  localparam int DRAIN_CYCLES   = 80;
  // Length of the receiver's long hold-off, taken twice in the run.
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_WORDS   = 1450;
  localparam int MAX_REPORTS    = 10;
  localparam longint unsigned CUM_CEILING = (64'd1 << cics_pkg::CUM_W) - 1;

  typedef struct packed {
    logic                          req_type;
    logic [cics_pkg::BIN_W-1:0]    bin_number;
    logic [cics_pkg::WEIGHT_W-1:0] weight;
    logic [cics_pkg::UNIF_W-1:0]   uniform;
  } sampler_word_t;

  typedef struct packed {
    logic [cics_pkg::CHOSEN_W-1:0] chosen_bin;
    logic                          status;
  } draw_result_t;

  // Shapes of the weight sets that a phase loads.
  typedef enum int unsigned {
    SHAPE_EMPTY,
    SHAPE_SPARSE,
    SHAPE_TINY,
    SHAPE_FULL,
    SHAPE_SPREAD
  } weight_shape_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [cics_pkg::CFG_IDX_W-1:0]  cfg_index = cics_pkg::CFG_BINS_IN_USE;
  logic [cics_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cics_in_if  in_bus();
  cics_out_if out_bus();

  categorical_inverse_cdf_sampler_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Local copy of the block's state: cumulative weights and the two registers.
  logic [cics_pkg::CUM_W-1:0]   cum_model [cics_pkg::MAX_BINS_DEF];
  logic [cics_pkg::COUNT_W-1:0] bins_shadow = 7'd1;
  logic                         base_shadow = 1'b0;

  draw_result_t  expected_draws[$];   // predicted draw results, oldest first
  sampler_word_t word_queue[$];       // words waiting to be offered
  sampler_word_t word_on_bus;         // word currently offered on the input

  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned draws_checked = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_gap      = 0;
  int unsigned hold_left     = 0;
  bit          quiet_mode    = 1'b0;  // no idling on either side while set

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A load stores the cumulative weight of the bin below plus its own weight,
  // saturating at the top of the 22-bit range.
  function automatic void apply_load(logic [cics_pkg::BIN_W-1:0] bin,
                                     logic [cics_pkg::WEIGHT_W-1:0] w);
    longint unsigned sum;
    if (bin >= cics_pkg::MAX_BINS_DEF) return;
    sum = (bin == 0) ? 64'd0 : cum_model[bin - 1];
    sum += w;
    if (sum > CUM_CEILING) sum = CUM_CEILING;
    cum_model[bin] = cics_pkg::CUM_W'(sum);
  endfunction

  // A draw picks the lowest bin whose cumulative weight, scaled by 2^32, is at
  // least uniform * total. The compare is exact 64-bit arithmetic. If no bin
  // qualifies, the last bin in use is taken.
  function automatic draw_result_t forecast_draw(logic [cics_pkg::UNIF_W-1:0] u);
    int unsigned     n;
    int unsigned     pick;
    longint unsigned total;
    longint unsigned target;
    longint unsigned entry;
    draw_result_t    r;
    n = bins_shadow;
    if (n == 0) n = 1;
    if (n > cics_pkg::MAX_BINS_DEF) n = cics_pkg::MAX_BINS_DEF;
    if (n > cics_pkg::BIN_FIELD_LIMIT) n = cics_pkg::BIN_FIELD_LIMIT;
    total = cum_model[n - 1];
    if (total == 0) begin
      r.chosen_bin = '0;
      r.status     = cics_pkg::STATUS_ZERO;
      return r;
    end
    target = total * u;
    pick   = n - 1;
    // Walking downward leaves the lowest qualifying bin in pick.
    for (int k = int'(n) - 1; k >= 0; k--) begin
      entry = cum_model[k];
      if (target <= (entry << 32)) pick = k;
    end
    r.chosen_bin = cics_pkg::CHOSEN_W'(pick + base_shadow);
    r.status     = cics_pkg::STATUS_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idling and failure reporting
  // --------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(string what, draw_result_t want, draw_result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] %s: expected bin %0d status %0d, got bin %0d status %0d",
               $realtime, what, want.chosen_bin, want.status, got.chosen_bin, got.status);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers queued words, predicts each word as it is accepted.
  // Valid stays high across back-to-back words, so it gets one assignment per
  // edge at most.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.req_type   <= cics_pkg::REQ_LOAD;
      in_bus.bin_number <= '0;
      in_bus.weight     <= '0;
      in_bus.uniform    <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (word_on_bus.req_type == cics_pkg::REQ_LOAD) begin
          apply_load(word_on_bus.bin_number, word_on_bus.weight);
        end else begin
          expected_draws.push_back(forecast_draw(word_on_bus.uniform));
        end
        words_taken++;
        send_gap = gap_length();
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          word_on_bus          = word_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.req_type   <= word_on_bus.req_type;
          in_bus.bin_number <= word_on_bus.bin_number;
          in_bus.weight     <= word_on_bus.weight;
          in_bus.uniform    <= word_on_bus.uniform;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted result word against the oldest
  // prediction and throttles ready. After the 150th and the 450th result the
  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the block stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_result_t got;
    draw_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.chosen_bin = out_bus.chosen_bin;
        got.status     = out_bus.status;
        draws_checked++;
        if (expected_draws.size() == 0) begin
          note_failure("result with no draw pending", '0, got);
        end else begin
          want = expected_draws.pop_front();
          if (got.chosen_bin !== want.chosen_bin || got.status !== want.status)
            note_failure("draw mismatch", want, got);
        end
        if (draws_checked == 150 || draws_checked == 450) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
        hold_left = gap_length();
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_bus.valid && in_bus.ready) ||
        (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_word(logic rt, logic [cics_pkg::BIN_W-1:0] bin,
                            logic [cics_pkg::WEIGHT_W-1:0] w,
                            logic [cics_pkg::UNIF_W-1:0] u);
    sampler_word_t item;
    item.req_type   = rt;
    item.bin_number = bin;
    item.weight     = w;
    item.uniform    = u;
    word_queue.push_back(item);
    words_queued++;
  endtask

  // Fields that a word type ignores carry random values.
  task automatic queue_load(int unsigned bin, logic [cics_pkg::WEIGHT_W-1:0] w);
    queue_word(cics_pkg::REQ_LOAD, cics_pkg::BIN_W'(bin), w, $urandom());
  endtask

  task automatic queue_draw(logic [cics_pkg::UNIF_W-1:0] u);
    queue_word(cics_pkg::REQ_DRAW, cics_pkg::BIN_W'($urandom()),
               cics_pkg::WEIGHT_W'($urandom()), u);
  endtask

  function automatic weight_shape_t random_shape();
    int unsigned roll;
    roll = $urandom_range(0, 5);
    return (roll >= 4) ? SHAPE_SPREAD : weight_shape_t'(roll);
  endfunction

  function automatic logic [cics_pkg::WEIGHT_W-1:0] pick_weight(weight_shape_t shape);
    case (shape)
      SHAPE_EMPTY:  return '0;
      SHAPE_SPARSE: return ($urandom_range(0, 3) == 0) ?
                           cics_pkg::WEIGHT_W'($urandom()) : '0;
      SHAPE_TINY:   return cics_pkg::WEIGHT_W'($urandom_range(0, 3));
      SHAPE_FULL:   return '1;
      default:      return cics_pkg::WEIGHT_W'($urandom());
    endcase
  endfunction

  // Most phases search only a few bins, since a draw's search grows with the bins.
  // Out-of-range values are kept in: zero counts as one bin, anything above
  // 64 is clamped to 64.
  function automatic logic [cics_pkg::COUNT_W-1:0] random_bins();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 14) return cics_pkg::COUNT_W'($urandom_range(65, 127));
    if (roll < 20) return cics_pkg::COUNT_W'(64);
    if (roll < 70) return cics_pkg::COUNT_W'($urandom_range(1, 8));
    return cics_pkg::COUNT_W'($urandom_range(9, 63));
  endfunction

  // Waits until every word has been accepted and every result collected, then
  // lets the block finish any load still in flight.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (words_taken != words_queued || expected_draws.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the block idle. The index base word
  // carries random upper bits, which the block must ignore.
  task automatic program_sampler(logic [cics_pkg::COUNT_W-1:0] bins_raw, logic base);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= cics_pkg::CFG_BINS_IN_USE;
    cfg_wdata <= cics_pkg::CFG_DATA_W'(bins_raw);
    @(posedge clk);
    cfg_index <= cics_pkg::CFG_INDEX_BASE;
    cfg_wdata <= cics_pkg::CFG_DATA_W'({$urandom(), base});
    @(posedge clk);
    cfg_we <= 1'b0;
    bins_shadow = bins_raw;
    base_shadow = base;
  endtask

  // One phase: program the registers, load every bin in use in ascending
  // order, then draw. Now and then a bin is reloaded out of order, which can
  // leave the cumulative table non-monotonic. Some draws aim exactly at a bin
  // boundary, or one step above it, while the table is still a plain prefix
  // sum that this task can work out by itself.
  task automatic run_random_phase(logic [cics_pkg::COUNT_W-1:0] bins_raw,
                                  inout int unsigned made);
    int unsigned     active;
    int unsigned     draws;
    int unsigned     roll;
    int unsigned     k;
    int unsigned     top_bin;
    longint unsigned prefix [cics_pkg::MAX_BINS_DEF];
    longint unsigned total;
    longint unsigned cut_u;
    logic [cics_pkg::WEIGHT_W-1:0] w;
    weight_shape_t   shape;
    bit              reshaped;
    active = (bins_raw == 0) ? 1 :
             ((bins_raw > cics_pkg::MAX_BINS_DEF) ? cics_pkg::MAX_BINS_DEF : bins_raw);
    program_sampler(bins_raw, 1'($urandom_range(0, 1)));
    quiet_mode = ($urandom_range(0, 99) < 15);
    shape = random_shape();
    for (k = 0; k < active; k++) begin
      w = pick_weight(shape);
      prefix[k] = ((k == 0) ? 64'd0 : prefix[k - 1]) + w;
      queue_load(k, w);
    end
    made += active;
    total    = prefix[active - 1];
    reshaped = 1'b0;
    top_bin  = (active < cics_pkg::MAX_BINS_DEF) ? active : cics_pkg::MAX_BINS_DEF - 1;
    draws    = $urandom_range(10, 36);
    repeat (draws) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // Bins up to one above the last in use all have a loaded predecessor.
        queue_load($urandom_range(0, top_bin), pick_weight(random_shape()));
        reshaped = 1'b1;
      end else if (roll < 20) begin
        queue_draw('0);
      end else if (roll < 28) begin
        queue_draw('1);
      end else if (roll < 55 && !reshaped && total != 0) begin
        k     = $urandom_range(0, active - 1);
        cut_u = ((prefix[k] << 32) / total) + $urandom_range(0, 1);
        queue_draw((cut_u > 64'hFFFF_FFFF) ? '1 : cics_pkg::UNIF_W'(cut_u));
      end else begin
        queue_draw($urandom());
      end
      made++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned made;
    foreach (cum_model[i]) cum_model[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset registers: one bin, zero-based.
    // A single zero weight gives a zero total.
    queue_load(0, '0);
    queue_draw($urandom());
    // Full-scale weight with the smallest and largest fractions.
    queue_load(0, '1);
    queue_draw('0);
    queue_draw('1);

    // Four bins, one-based, with a zero-weight bin in the middle.
    program_sampler(7'd4, 1'b1);
    queue_load(1, 16'd1);
    queue_load(2, '0);
    queue_load(3, '1);
    queue_draw('0);
    queue_draw('1);
    queue_draw(32'h8000_0000);
    // Reloading bin 0 alone makes it smaller than before, so the table is no
    // longer the prefix sum of the latest weights.
    queue_load(0, 16'd7);
    queue_draw(32'h8000_0000);
    queue_draw(32'h0000_0001);

    // Zero bins in use counts as one bin.
    program_sampler(7'd0, 1'b0);
    queue_draw('1);
    queue_draw(32'h0000_0001);

    // Random part. The first two phases take the largest register value and
    // the largest bin count, which also loads every bin number once.
    made = 0;
    run_random_phase(7'd127, made);
    run_random_phase(7'd64, made);
    while (made < RANDOM_WORDS) run_random_phase(random_bins(), made);

    wait_for_drain();
    if (error_count == 0 && expected_draws.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
